FILE: rtl/ksc_pkg.sv
package ksc_pkg;

    localparam int unsigned DIGIT_W = 5;

    localparam logic [DIGIT_W-1:0] DIGIT_BLANK = 5'd16;
    localparam logic [DIGIT_W-1:0] DIGIT_ZERO  = 5'd0;
    localparam logic [DIGIT_W-1:0] DIGIT_ONE   = 5'd1;
    localparam logic [DIGIT_W-1:0] DIGIT_NINE  = 5'd9;

    localparam logic [3:0] KEY_STOP_A = 4'd10;
    localparam logic [3:0] KEY_STOP_B = 4'd11;
    localparam logic [3:0] KEY_CLEAR  = 4'd12;
    localparam logic [3:0] KEY_DELETE = 4'd13;
    localparam logic [3:0] KEY_FWD    = 4'd14;
    localparam logic [3:0] KEY_REV    = 4'd15;

    localparam logic OP_KEY  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [15:0] STEP_LIMIT_RESET = 16'd1000;

    localparam logic [3:0] COIL_FWD_START = 4'b0001;
    localparam logic [3:0] COIL_REV_START = 4'b1000;

    // Number of display digits that make up the run length.
    localparam int unsigned LEN_DIGITS = 5;
    localparam int unsigned LEN_W      = 17;
    localparam int unsigned OUT_DIGITS = 8;

    typedef enum logic [2:0] {
        KIND_TICK,
        KIND_DIGIT,
        KIND_STOP,
        KIND_CLEAR,
        KIND_DELETE,
        KIND_START
    } t_kind;

    typedef struct packed {
        logic       op;
        logic [3:0] key;
    } t_item;

    typedef struct packed {
        t_kind      kind;
        logic       reverse;
        logic [3:0] digit;
    } t_cmd;

    typedef struct packed {
        logic [3:0]  motor_phase;
        logic [39:0] display_codes;
        logic        running;
        logic        run_done;
        logic [15:0] steps_left;
    } t_result;

endpackage

FILE: rtl/ksc_fifo.sv
module ksc_fifo #(
    parameter int unsigned WIDTH = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;
    logic             w_wr_en;
    logic             w_rd_en;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign w_wr_en = i_wr && !o_full;
    assign w_rd_en = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_wr_en) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_rd_en) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({w_wr_en, w_rd_en})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: rtl/ksc_front.sv
module ksc_front (
    input  ksc_pkg::t_item i_item,
    output ksc_pkg::t_cmd  o_cmd
);

    // Classify the event; digits and the direction travel with the kind.
    always_comb begin
        o_cmd.digit   = i_item.key;
        o_cmd.reverse = (i_item.key == ksc_pkg::KEY_REV);
        if (i_item.op == ksc_pkg::OP_TICK) begin
            o_cmd.kind = ksc_pkg::KIND_TICK;
        end else begin
            unique case (i_item.key) inside
                ksc_pkg::KEY_STOP_A, ksc_pkg::KEY_STOP_B: o_cmd.kind = ksc_pkg::KIND_STOP;
                ksc_pkg::KEY_CLEAR:                       o_cmd.kind = ksc_pkg::KIND_CLEAR;
                ksc_pkg::KEY_DELETE:                      o_cmd.kind = ksc_pkg::KIND_DELETE;
                ksc_pkg::KEY_FWD, ksc_pkg::KEY_REV:       o_cmd.kind = ksc_pkg::KIND_START;
                default:                                  o_cmd.kind = ksc_pkg::KIND_DIGIT;
            endcase
        end
    end

endmodule

FILE: rtl/ksc_back.sv
module ksc_back #(
    parameter int unsigned NUM_DIGITS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [15:0]       i_step_limit,
    input  logic              i_cmd_valid,
    input  ksc_pkg::t_cmd     i_cmd,
    output logic              o_cmd_take,
    input  logic              i_res_full,
    output logic              o_res_valid,
    output ksc_pkg::t_result  o_result
);

    localparam int unsigned DW = ksc_pkg::DIGIT_W;

    logic [DW-1:0] r_digits [NUM_DIGITS];
    logic [DW-1:0] n_digits [NUM_DIGITS];
    logic [DW-1:0] w_cd     [NUM_DIGITS];
    logic [DW-1:0] w_edit   [NUM_DIGITS];
    logic [DW-1:0] w_blank  [NUM_DIGITS];

    logic [15:0] r_remaining;
    logic [15:0] n_remaining;
    logic [3:0]  r_coil;
    logic [3:0]  n_coil;
    logic [3:0]  r_latch;
    logic [3:0]  n_latch;
    logic        r_active;
    logic        n_active;
    logic        r_reverse;
    logic        n_reverse;
    logic        w_done;
    logic        w_do_blank;
    logic        w_fire;

    logic [ksc_pkg::LEN_W-1:0] w_len;
    logic [15:0]               w_run;
    logic [39:0]               w_codes;

    assign w_fire      = i_cmd_valid && !i_res_full;
    assign o_cmd_take  = w_fire;
    assign o_res_valid = w_fire;

    // BCD countdown of the low five digits; blank a digit that turns into a leading zero.
    always_comb begin
        logic borrow;
        borrow = 1'b1;
        w_cd = r_digits;
        for (int k = 0; k < ksc_pkg::LEN_DIGITS; k++) begin
            if (borrow) begin
                if (r_digits[k] >= ksc_pkg::DIGIT_ONE && r_digits[k] <= ksc_pkg::DIGIT_NINE) begin
                    w_cd[k] = r_digits[k] - ksc_pkg::DIGIT_ONE;
                    borrow  = 1'b0;
                    if (k > 0 && w_cd[k] == ksc_pkg::DIGIT_ZERO
                        && r_digits[k+1] == ksc_pkg::DIGIT_BLANK) begin
                        w_cd[k] = ksc_pkg::DIGIT_BLANK;
                    end
                end else if (k < ksc_pkg::LEN_DIGITS - 1) begin
                    w_cd[k] = ksc_pkg::DIGIT_NINE;
                end else if (r_digits[k] == ksc_pkg::DIGIT_ZERO
                             && r_digits[k+1] == ksc_pkg::DIGIT_BLANK) begin
                    w_cd[k] = ksc_pkg::DIGIT_BLANK;
                end
            end
        end
    end

    // Decimal value of the low five digits; a non-numeric code counts as zero.
    always_comb begin
        logic [ksc_pkg::LEN_W-1:0] weight;
        logic [ksc_pkg::LEN_W-1:0] dval;
        w_len  = '0;
        weight = ksc_pkg::LEN_W'(1);
        for (int k = 0; k < ksc_pkg::LEN_DIGITS; k++) begin
            dval = (r_digits[k] <= ksc_pkg::DIGIT_NINE)
                   ? ksc_pkg::LEN_W'(r_digits[k]) : '0;
            w_len  = w_len + ksc_pkg::LEN_W'(dval * weight);
            weight = ksc_pkg::LEN_W'(weight * ksc_pkg::LEN_W'(10));
        end
    end

    assign w_run = (w_len > {1'b0, i_step_limit}) ? i_step_limit : w_len[15:0];

    // Key edits of the display buffer.
    always_comb begin
        w_edit = r_digits;
        case (i_cmd.kind)
            ksc_pkg::KIND_CLEAR: begin
                for (int k = 0; k < NUM_DIGITS; k++) begin
                    w_edit[k] = ksc_pkg::DIGIT_BLANK;
                end
            end
            ksc_pkg::KIND_DELETE: begin
                for (int k = 0; k < NUM_DIGITS - 1; k++) begin
                    w_edit[k] = r_digits[k+1];
                end
                w_edit[NUM_DIGITS-1] = ksc_pkg::DIGIT_BLANK;
            end
            ksc_pkg::KIND_DIGIT: begin
                for (int k = 1; k < NUM_DIGITS; k++) begin
                    w_edit[k] = r_digits[k-1];
                end
                w_edit[0] = {1'b0, i_cmd.digit};
            end
            default: w_edit = r_digits;
        endcase
    end

    // Leading-zero blanking, top digit down.
    always_comb begin
        w_blank = w_edit;
        for (int k = NUM_DIGITS - 2; k > 0; k--) begin
            if (w_blank[k] == ksc_pkg::DIGIT_ZERO && w_blank[k+1] == ksc_pkg::DIGIT_BLANK) begin
                w_blank[k] = ksc_pkg::DIGIT_BLANK;
            end
        end
    end

    always_comb begin
        n_digits    = r_digits;
        n_remaining = r_remaining;
        n_coil      = r_coil;
        n_latch     = r_latch;
        n_active    = r_active;
        n_reverse   = r_reverse;
        w_done      = 1'b0;
        w_do_blank  = 1'b0;
        if (i_cmd.kind == ksc_pkg::KIND_TICK) begin
            if (r_active) begin
                n_latch     = r_coil;
                n_coil      = r_reverse ? {r_coil[0], r_coil[3:1]} : {r_coil[2:0], r_coil[3]};
                n_digits    = w_cd;
                n_remaining = r_remaining - 16'd1;
                if (r_remaining == 16'd1) begin
                    n_active = 1'b0;
                    w_done   = 1'b1;
                end
            end
        end else if (r_active) begin
            if (i_cmd.kind == ksc_pkg::KIND_STOP) begin
                n_active    = 1'b0;
                n_remaining = '0;
                w_done      = 1'b1;
                w_do_blank  = 1'b1;
            end
        end else begin
            w_do_blank = 1'b1;
            if (i_cmd.kind == ksc_pkg::KIND_START) begin
                n_reverse   = i_cmd.reverse;
                n_coil      = i_cmd.reverse ? ksc_pkg::COIL_REV_START : ksc_pkg::COIL_FWD_START;
                n_remaining = w_run;
                if (w_run == 16'd0) begin
                    w_done = 1'b1;
                end else begin
                    n_active = 1'b1;
                end
            end
        end
        if (w_do_blank) begin
            n_digits = w_blank;
        end
    end

    for (genvar g = 0; g < ksc_pkg::OUT_DIGITS; g++) begin : g_codes
        if (g < NUM_DIGITS) begin : g_have
            assign w_codes[g*DW +: DW] = n_digits[g];
        end else begin : g_none
            assign w_codes[g*DW +: DW] = '0;
        end
    end

    assign o_result.motor_phase   = n_latch;
    assign o_result.display_codes = w_codes;
    assign o_result.running       = n_active;
    assign o_result.run_done      = w_done;
    assign o_result.steps_left    = n_active ? n_remaining : 16'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digits[0] <= ksc_pkg::DIGIT_ZERO;
            for (int k = 1; k < NUM_DIGITS; k++) begin
                r_digits[k] <= ksc_pkg::DIGIT_BLANK;
            end
            r_remaining <= '0;
            r_coil      <= ksc_pkg::COIL_FWD_START;
            r_latch     <= '0;
            r_active    <= 1'b0;
            r_reverse   <= 1'b0;
        end else if (w_fire) begin
            r_digits    <= n_digits;
            r_remaining <= n_remaining;
            r_coil      <= n_coil;
            r_latch     <= n_latch;
            r_active    <= n_active;
            r_reverse   <= n_reverse;
        end
    end

endmodule

FILE: rtl/keypad_stepper_step_counter.sv
// Channel   Direction  Handshake                 Payload
// -------   ---------  ------------------------  ------------------------------
// events    in         push / full               i_item   (op, key)
// results   out        empty / pop               o_result (phase, display, status)
// config    in         psel/penable/pwrite/ready paddr, pwdata, prdata (step_limit)
//
// One event is taken per cycle while full is low; each event gives exactly one result.
// Each event passes through the command queue, then through the execution
// unit into the result queue.
// Reset is synchronous, active low; the display comes up as a single "0".
// The 2-entry command and result queues let either side stall on its own;
// full rises only when both queues are backed up.
module keypad_stepper_step_counter #(
    parameter int unsigned NUM_DIGITS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,

    input  logic              push,
    output logic              full,
    input  ksc_pkg::t_item    i_item,

    output logic              empty,
    input  logic              pop,
    output ksc_pkg::t_result  o_result,

    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [1:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [15:0]      r_step_limit;
    ksc_pkg::t_cmd    w_front_cmd;
    ksc_pkg::t_cmd    w_queue_cmd;
    logic             w_cmd_empty;
    logic             w_cmd_take;
    logic             w_res_full;
    logic             w_res_valid;
    ksc_pkg::t_result w_back_res;

    // Configuration: step_limit is the only register, at address 0.
    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {16'd0, r_step_limit} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_limit <= ksc_pkg::STEP_LIMIT_RESET;
        end else if (psel && penable && pwrite && pready && paddr == 2'd0) begin
            r_step_limit <= pwdata[15:0];
        end
    end

    // Front: classify each event as it is transferred in.
    ksc_front u_front (
        .i_item (i_item),
        .o_cmd  (w_front_cmd)
    );

    // Hold classified commands until the back end takes them.
    ksc_fifo #(
        .WIDTH ($bits(ksc_pkg::t_cmd))
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (push),
        .i_wdata (w_front_cmd),
        .o_full  (full),
        .i_rd    (w_cmd_take),
        .o_rdata (w_queue_cmd),
        .o_empty (w_cmd_empty)
    );

    // Back: advance the display, run counter and coil drive.
    ksc_back #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step_limit (r_step_limit),
        .i_cmd_valid  (!w_cmd_empty),
        .i_cmd        (w_queue_cmd),
        .o_cmd_take   (w_cmd_take),
        .i_res_full   (w_res_full),
        .o_res_valid  (w_res_valid),
        .o_result     (w_back_res)
    );

    // Results wait here until popped.
    ksc_fifo #(
        .WIDTH ($bits(ksc_pkg::t_result))
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_res_valid),
        .i_wdata (w_back_res),
        .o_full  (w_res_full),
        .i_rd    (pop),
        .o_rdata (o_result),
        .o_empty (empty)
    );

endmodule

FILE: tb/keypad_stepper_step_counter_tb.sv
// Scoreboard: mirrors the controller state, predicts one status transfer per
// accepted event and checks returned transfers in order.
class stepper_scoreboard;
    localparam int DIGITS = 8;

    logic [15:0]      step_limit;
    logic [4:0]       digits [DIGITS];
    logic [15:0]      steps_to_go;
    logic [3:0]       next_coil;
    logic [3:0]       coil_latch;
    bit               active;
    bit               run_rev;
    ksc_pkg::t_result due_status [$];
    int               mismatches;

    function new();
        int k;
        step_limit  = ksc_pkg::STEP_LIMIT_RESET;
        for (k = 0; k < DIGITS; k++) digits[k] = ksc_pkg::DIGIT_BLANK;
        digits[0]   = ksc_pkg::DIGIT_ZERO;
        steps_to_go = '0;
        next_coil   = ksc_pkg::COIL_FWD_START;
        coil_latch  = '0;
        active      = 0;
        run_rev     = 0;
        mismatches  = 0;
    endfunction

    task report(string msg);
        mismatches++;
        $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    function bit is_pos(logic [4:0] d);
        return d >= ksc_pkg::DIGIT_ONE && d <= ksc_pkg::DIGIT_NINE;
    endfunction

    function void clear_leading();
        int k;
        for (k = DIGITS - 2; k > 0; k--)
            if (digits[k] == ksc_pkg::DIGIT_ZERO && digits[k+1] == ksc_pkg::DIGIT_BLANK)
                digits[k] = ksc_pkg::DIGIT_BLANK;
    endfunction

    function logic [16:0] length_value();
        int total;
        int weight;
        int k;
        total  = 0;
        weight = 1;
        for (k = 0; k < ksc_pkg::LEN_DIGITS; k++) begin
            if (digits[k] <= ksc_pkg::DIGIT_NINE) total += int'(digits[k]) * weight;
            weight *= 10;
        end
        return total[16:0];
    endfunction

    // BCD countdown over the five length digits, blanking new leading zeros.
    function void count_down_display();
        int k;
        if (is_pos(digits[0])) begin
            digits[0] = digits[0] - 5'd1;
            return;
        end
        digits[0] = ksc_pkg::DIGIT_NINE;
        for (k = 1; k <= 3; k++) begin
            if (is_pos(digits[k])) begin
                digits[k] = digits[k] - 5'd1;
                if (digits[k] == ksc_pkg::DIGIT_ZERO && digits[k+1] == ksc_pkg::DIGIT_BLANK)
                    digits[k] = ksc_pkg::DIGIT_BLANK;
                return;
            end
            digits[k] = ksc_pkg::DIGIT_NINE;
        end
        if (is_pos(digits[4])) digits[4] = digits[4] - 5'd1;
        if (digits[4] == ksc_pkg::DIGIT_ZERO && digits[5] == ksc_pkg::DIGIT_BLANK)
            digits[4] = ksc_pkg::DIGIT_BLANK;
    endfunction

    function ksc_pkg::t_result advance(ksc_pkg::t_item it);
        ksc_pkg::t_result res;
        logic [4:0]       shifted;
        logic [16:0]      len;
        bit               done;
        int               k;
        done = 0;
        if (it.op == ksc_pkg::OP_TICK) begin
            if (active) begin
                coil_latch = next_coil;
                if (run_rev) begin
                    next_coil = next_coil >> 1;
                    if (next_coil == 4'd0) next_coil = ksc_pkg::COIL_REV_START;
                end else begin
                    shifted   = {next_coil, 1'b0};
                    next_coil = (shifted == 5'h10 || shifted == 5'd0) ?
                                ksc_pkg::COIL_FWD_START : shifted[3:0];
                end
                count_down_display();
                steps_to_go = steps_to_go - 16'd1;
                if (steps_to_go == 16'd0) begin
                    active = 0;
                    done   = 1;
                end
            end
        end else if (active) begin
            if (it.key == ksc_pkg::KEY_STOP_A || it.key == ksc_pkg::KEY_STOP_B) begin
                active      = 0;
                steps_to_go = '0;
                done        = 1;
                clear_leading();
            end
        end else begin
            case (it.key)
                ksc_pkg::KEY_CLEAR: begin
                    for (k = 0; k < DIGITS; k++) digits[k] = ksc_pkg::DIGIT_BLANK;
                end
                ksc_pkg::KEY_DELETE: begin
                    for (k = 0; k < DIGITS - 1; k++) digits[k] = digits[k+1];
                    digits[DIGITS-1] = ksc_pkg::DIGIT_BLANK;
                end
                ksc_pkg::KEY_FWD, ksc_pkg::KEY_REV: begin
                    len = length_value();
                    if (len > {1'b0, step_limit}) len = {1'b0, step_limit};
                    run_rev     = (it.key == ksc_pkg::KEY_REV);
                    next_coil   = run_rev ? ksc_pkg::COIL_REV_START : ksc_pkg::COIL_FWD_START;
                    steps_to_go = len[15:0];
                    if (len == 17'd0) done = 1;
                    else active = 1;
                end
                ksc_pkg::KEY_STOP_A, ksc_pkg::KEY_STOP_B: ;
                default: begin
                    for (k = DIGITS - 1; k > 0; k--) digits[k] = digits[k-1];
                    digits[0] = {1'b0, it.key};
                end
            endcase
            clear_leading();
        end

        res = '0;
        for (k = 0; k < ksc_pkg::OUT_DIGITS && k < DIGITS; k++)
            res.display_codes[5*k +: 5] = digits[k];
        res.motor_phase = coil_latch;
        res.running     = active;
        res.run_done    = done;
        res.steps_left  = active ? steps_to_go : 16'd0;
        return res;
    endfunction

    // Queue the predicted status for an accepted event.
    function void note_event(ksc_pkg::t_item it);
        due_status.push_back(advance(it));
    endfunction

    task check_status(ksc_pkg::t_result got);
        ksc_pkg::t_result want;
        if (due_status.size() == 0) begin
            report("status transfer with no event pending");
            return;
        end
        want = due_status.pop_front();
        if (got.motor_phase !== want.motor_phase)
            report($sformatf("motor_phase got %h want %h", got.motor_phase, want.motor_phase));
        if (got.display_codes !== want.display_codes)
            report($sformatf("display_codes got %h want %h",
                             got.display_codes, want.display_codes));
        if (got.running !== want.running)
            report($sformatf("running got %b want %b", got.running, want.running));
        if (got.run_done !== want.run_done)
            report($sformatf("run_done got %b want %b", got.run_done, want.run_done));
        if (got.steps_left !== want.steps_left)
            report($sformatf("steps_left got %0d want %0d", got.steps_left, want.steps_left));
    endtask
endclass

module keypad_stepper_step_counter_tb;

    localparam int unsigned NUM_DIGITS      = 8;
    localparam logic [1:0]  ADDR_STEP_LIMIT = 2'd0;
    localparam int          CHUNK_EVENTS    = 150;

    logic             i_clk   = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             push    = 1'b0;
    logic             full;
    ksc_pkg::t_item   i_item  = '0;
    logic             empty;
    logic             pop     = 1'b0;
    ksc_pkg::t_result o_result;
    logic             psel    = 1'b0;
    logic             penable = 1'b0;
    logic             pwrite  = 1'b0;
    logic [1:0]       paddr   = '0;
    logic [31:0]      pwdata  = '0;
    logic [31:0]      prdata;
    logic             pready;

    stepper_scoreboard sb = new();

    // Idle bursts stop in the final part of the run.
    bit calm       = 0;
    int sent_cnt   = 0;
    int pop_hold   = 0;

    keypad_stepper_step_counter #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Receiver: hold pop low for random bursts, otherwise keep draining the
    // status queue.
    always @(negedge i_clk) begin
        if (pop_hold > 0) begin
            pop      <= 1'b0;
            pop_hold <= pop_hold - 1;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            pop      <= 1'b0;
            pop_hold <= $urandom_range(0, 3);
        end else begin
            pop <= 1'b1;
        end
    end

    // Check every status transfer against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) sb.check_status(o_result);
    end

    // Offer one event, optionally after an idle burst, and hold it until the
    // block takes it. Push stays high on exit so back-to-back events do not
    // drop it in between.
    task send_event(logic op, logic [3:0] key);
        ksc_pkg::t_item it;
        int             gap;
        it.op  = op;
        it.key = key;
        if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 4);
            repeat (gap) begin
                @(negedge i_clk);
                push <= 1'b0;
            end
        end
        @(negedge i_clk);
        push   <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (full);
        sb.note_event(it);
        sent_cnt++;
    endtask

    task send_key(logic [3:0] key);
        send_event(ksc_pkg::OP_KEY, key);
    endtask

    // Key bits on a tick are don't-care; randomize them anyway.
    task send_tick();
        send_event(ksc_pkg::OP_TICK, 4'($urandom_range(0, 15)));
    endtask

    // Drop push and wait for every predicted status, then let the pipeline
    // settle so nothing is in flight.
    task drain_status();
        int guard;
        guard = 0;
        @(negedge i_clk);
        push <= 1'b0;
        while (sb.due_status.size() != 0 && guard < 5000) begin
            @(posedge i_clk);
            guard++;
        end
        if (sb.due_status.size() != 0)
            sb.report($sformatf("%0d status transfers never arrived", sb.due_status.size()));
        repeat (4) @(posedge i_clk);
    endtask

    // APB write of step_limit, then read it back.
    task write_step_limit(logic [15:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_STEP_LIMIT;
        pwdata  <= {16'h0, value};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.step_limit = value;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== {16'h0, value})
            sb.report($sformatf("step_limit read %h want %h", prdata, value));
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Mostly well-formed sessions: optional clear, a few digits (zeros
    // favored so the countdown has to borrow), optional delete, a start,
    // some ticks with stray keys mixed in, then a stop key. The rest is noise.
    task run_sessions(int quota);
        int target;
        int n;
        int ticks;
        target = sent_cnt + quota;
        while (sent_cnt < target) begin
            if ($urandom_range(0, 9) < 2) begin
                send_event(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
            end else begin
                if ($urandom_range(0, 3) == 0) send_key(ksc_pkg::KEY_CLEAR);
                n = ($urandom_range(0, 4) == 0) ? $urandom_range(3, 6) : $urandom_range(1, 2);
                repeat (n)
                    send_key(($urandom_range(0, 2) == 0) ? 4'd0 : 4'($urandom_range(0, 9)));
                if ($urandom_range(0, 5) == 0) send_key(ksc_pkg::KEY_DELETE);
                send_key($urandom_range(0, 1) ? ksc_pkg::KEY_FWD : ksc_pkg::KEY_REV);
                ticks = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 5)
                                                    : $urandom_range(5, 40);
                repeat (ticks) begin
                    if ($urandom_range(0, 7) == 0) send_key(4'($urandom_range(0, 15)));
                    send_tick();
                end
                send_key($urandom_range(0, 1) ? ksc_pkg::KEY_STOP_A : ksc_pkg::KEY_STOP_B);
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: tick while idle, zero-length start, stop keys while idle,
        // leading zero, all digits, delete, clear, delete on a blank display,
        // a short reverse run with an ignored key that ends on its own,
        // and a forward run ended by a stop key.
        send_tick();
        send_key(ksc_pkg::KEY_FWD);
        send_key(ksc_pkg::KEY_STOP_A);
        send_key(ksc_pkg::KEY_STOP_B);
        send_key(4'd0);
        for (int d = 9; d >= 1; d--) send_key(4'(d));
        send_key(ksc_pkg::KEY_DELETE);
        send_key(ksc_pkg::KEY_DELETE);
        send_key(ksc_pkg::KEY_CLEAR);
        send_key(ksc_pkg::KEY_DELETE);
        send_key(4'd3);
        send_key(ksc_pkg::KEY_REV);
        send_key(4'd5);
        repeat (3) send_tick();
        send_key(4'd2);
        send_key(ksc_pkg::KEY_FWD);
        send_tick();
        send_key(ksc_pkg::KEY_STOP_A);

        run_sessions(CHUNK_EVENTS);

        // Walk step_limit through its extremes and a few small values. Each
        // write waits for the block to go idle first.
        drain_status();
        write_step_limit(16'hFFFF);
        run_sessions(CHUNK_EVENTS);
        drain_status();
        write_step_limit(16'd0);
        run_sessions(CHUNK_EVENTS);
        drain_status();
        write_step_limit(16'd1);
        run_sessions(CHUNK_EVENTS);
        drain_status();
        write_step_limit(16'd9);
        run_sessions(CHUNK_EVENTS);
        drain_status();
        write_step_limit(16'($urandom_range(10, 200)));
        calm = 1;
        run_sessions(CHUNK_EVENTS);

        drain_status();
        repeat (8) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog well beyond the slowest legal run.
    initial begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end
endmodule
